// ===== sv/hds_pkg.sv =====
// Shared types and constants for the heat diffusion stencil.
// No dependencies; imported by every module of the block.
package hds_pkg;

    // Cell values are unsigned Q1.15
    localparam int VALUE_BITS = 16;
    localparam int SUM_BITS = VALUE_BITS + 2;
    localparam int HDS_MAX_WIDTH = 1024;

    // Configuration port
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS = 16;
    localparam int ROW_WIDTH_BITS = 11;
    localparam int ROW_COUNT_BITS = 16;
    localparam int ROW_INDEX_BITS = 17;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_WIDTH = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_COUNT = CFG_INDEX_BITS'(1);
    localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = ROW_WIDTH_BITS'(1024);
    localparam logic [ROW_COUNT_BITS-1:0] ROW_COUNT_RESET = ROW_COUNT_BITS'(256);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // One stencil job: the four operands plus column/frame flags
    typedef struct packed {
        logic [VALUE_BITS-1:0] up;
        logic [VALUE_BITS-1:0] center;
        logic [VALUE_BITS-1:0] left;
        logic [VALUE_BITS-1:0] right;
        logic                  first_col;
        logic                  last_col;
        logic                  last_frame;
    } hds_item_t;

    typedef struct packed {
        logic [QCNT_BITS-1:0] count;
        logic                 full;
        logic                 empty;
    } hds_qstat_t;

endpackage

// ===== sv/hds_queue.sv =====
// Short job queue between the stencil front end and the arithmetic back end.
// Depends on hds_pkg.
module hds_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hds_pkg::hds_item_t push_item,
    input  logic               pop,
    output hds_pkg::hds_item_t head_item,
    output hds_pkg::hds_qstat_t stat
);
    import hds_pkg::*;

    hds_item_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign stat.count = count_reg;
    assign stat.full  = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= QPTR_BITS'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= QPTR_BITS'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= QCNT_BITS'(count_reg + 1'b1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= QCNT_BITS'(count_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // fill level rises by one on a push without a pop
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == QCNT_BITS'($past(count_reg) + 1'b1)))
        else $error("queue count did not follow a push");

endmodule

// ===== sv/hds_front.sv =====
// Stencil front end: input beats, config registers, row/column tracking,
// the two line memories and operand gathering. Depends on hds_pkg.
module hds_front #(
    parameter int MAX_WIDTH = hds_pkg::HDS_MAX_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [hds_pkg::VALUE_BITS-1:0]     cell_value,
    input  logic                               start_of_frame,
    input  logic                               cfg_valid,
    input  logic [hds_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [hds_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  hds_pkg::hds_qstat_t                qstat,
    output logic                               push,
    output hds_pkg::hds_item_t                 push_item
);
    import hds_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCMP = ($clog2(MAX_WIDTH + 1) > ROW_WIDTH_BITS) ?
                          $clog2(MAX_WIDTH + 1) : ROW_WIDTH_BITS;

    logic [ROW_WIDTH_BITS-1:0] row_width_reg;
    logic [ROW_COUNT_BITS-1:0] row_count_reg;
    logic [AW-1:0]             col_reg;
    logic [ROW_INDEX_BITS-1:0] row_reg;
    logic [VALUE_BITS-1:0]     left_reg;

    // stage 1: memory read data lands here
    logic                      s1_valid_reg;
    logic [AW-1:0]             s1_addr_reg;
    logic [VALUE_BITS-1:0]     s1_cell_reg;
    logic                      s1_first_reg;
    logic                      s1_last_reg;
    logic                      s1_emit_reg;
    logic                      s1_lastf_reg;
    logic                      byp_reg;
    logic [VALUE_BITS-1:0]     byp_val_reg;
    logic [VALUE_BITS-1:0]     up_rd_reg;
    logic [VALUE_BITS-1:0]     mid_rd_reg;
    logic [VALUE_BITS-1:0]     right_rd_reg;

    logic [VALUE_BITS-1:0]     upper_mem  [MAX_WIDTH];
    logic [VALUE_BITS-1:0]     middle_mem [MAX_WIDTH];

    logic [WCMP-1:0]           rw_ext;
    logic [AW-1:0]             wm1;
    logic [ROW_COUNT_BITS-1:0] rows_eff;
    logic [ROW_INDEX_BITS-1:0] last_row;
    logic [AW-1:0]             col_eff;
    logic [ROW_INDEX_BITS-1:0] row_eff;
    logic [AW-1:0]             col_c;
    logic [AW-1:0]             col_nx;
    logic                      first_col;
    logic                      last_col;
    logic                      skip;
    logic                      accept;
    logic                      proc;

    // clamp registers to their working range
    always_comb
    begin
        rw_ext = WCMP'(row_width_reg);
        if (rw_ext < WCMP'(2))
        begin
            wm1 = AW'(1);
        end
        else if (rw_ext > WCMP'(MAX_WIDTH))
        begin
            wm1 = AW'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1 = AW'(rw_ext - 1'b1);
        end
        rows_eff = (row_count_reg < ROW_COUNT_BITS'(2)) ? ROW_COUNT_BITS'(2) : row_count_reg;
        last_row = ROW_INDEX_BITS'(rows_eff) + ROW_INDEX_BITS'(1);
    end

    // classify the arriving beat
    assign col_eff   = start_of_frame ? '0 : col_reg;
    assign row_eff   = start_of_frame ? '0 : row_reg;
    assign col_c     = (col_eff > wm1) ? wm1 : col_eff;
    assign col_nx    = AW'(col_c + 1'b1);
    assign first_col = (col_c == '0);
    assign last_col  = (col_c == wm1);
    assign skip      = (row_eff > last_row);

    assign s_tready = (QCNT_BITS'(qstat.count + QCNT_BITS'(s1_valid_reg))
                       < QCNT_BITS'(QUEUE_DEPTH));
    assign accept   = s_tvalid && s_tready;
    assign proc     = accept && !skip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
            row_count_reg <= ROW_COUNT_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            byp_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_ROW_WIDTH: row_width_reg <= cfg_data[ROW_WIDTH_BITS-1:0];
                    CFG_ROW_COUNT: row_count_reg <= cfg_data[ROW_COUNT_BITS-1:0];
                    default: ;
                endcase
            end
            if (proc)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= ROW_INDEX_BITS'(row_eff + 1'b1);
                end
                else
                begin
                    col_reg <= col_nx;
                    row_reg <= row_eff;
                end
            end
            if (s1_valid_reg)
            begin
                left_reg <= mid_rd_reg;
            end
            s1_valid_reg <= proc;
            // upper write of the stage-1 beat lands at this edge; forward it
            byp_reg      <= proc && s1_valid_reg && (col_c == s1_addr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            s1_addr_reg  <= col_c;
            s1_cell_reg  <= cell_value;
            s1_first_reg <= first_col;
            s1_last_reg  <= last_col;
            s1_emit_reg  <= (row_eff >= ROW_INDEX_BITS'(2));
            s1_lastf_reg <= last_col && (row_eff == last_row);
        end
        byp_val_reg <= mid_rd_reg;
    end

    // middle line: read current and right neighbor, write arriving cell
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            mid_rd_reg         <= middle_mem[col_c];
            right_rd_reg       <= middle_mem[col_nx];
            middle_mem[col_c]  <= cell_value;
        end
    end

    // upper line: read now, written in the following cycle with the old middle
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            up_rd_reg <= upper_mem[col_c];
        end
        if (s1_valid_reg)
        begin
            upper_mem[s1_addr_reg] <= mid_rd_reg;
        end
    end

    assign push                 = s1_valid_reg && s1_emit_reg;
    assign push_item.up         = byp_reg ? byp_val_reg : up_rd_reg;
    assign push_item.center     = s1_cell_reg;
    assign push_item.left       = left_reg;
    assign push_item.right      = right_rd_reg;
    assign push_item.first_col  = s1_first_reg;
    assign push_item.last_col   = s1_last_reg;
    assign push_item.last_frame = s1_lastf_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("job pushed into a full queue");

    a_bypass_src: assert property (@(posedge clk) disable iff (!rst_n)
        byp_reg |-> ($past(s1_valid_reg) && s1_valid_reg))
        else $error("upper-line forward without a pending write");

endmodule

// ===== sv/hds_back.sv =====
// Stencil back end: neighbor sum, divide by three or four, output register.
// Depends on hds_pkg.
module hds_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hds_pkg::hds_item_t             head_item,
    input  hds_pkg::hds_qstat_t            qstat,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hds_pkg::VALUE_BITS-1:0] new_value,
    output logic                           last_in_row,
    output logic                           last_in_frame
);
    import hds_pkg::*;

    // floor(x/3) = (x * ceil(2^K/3)) >> K, exact for x < 2^SUM_BITS
    localparam int DIV3_SHIFT = SUM_BITS + 1;
    localparam logic [SUM_BITS-1:0] DIV3_MUL =
        SUM_BITS'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);

    logic                  a_valid_reg;
    logic [SUM_BITS-1:0]   a_sum_reg;
    logic                  a_div3_reg;
    logic                  a_last_reg;
    logic                  a_lastf_reg;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_data_reg;
    logic                  out_last_reg;
    logic                  out_lastf_reg;

    logic                  out_adv;
    logic                  a_load;
    logic [SUM_BITS-1:0]   sum;
    logic [2*SUM_BITS-1:0] prod;
    logic [VALUE_BITS-1:0] quot;

    assign out_adv = !out_valid_reg || m_tready;
    assign a_load  = !a_valid_reg || out_adv;
    assign pop     = a_load && !qstat.empty;

    always_comb
    begin
        sum = SUM_BITS'(head_item.up) + SUM_BITS'(head_item.center);
        if (!head_item.first_col)
        begin
            sum = sum + SUM_BITS'(head_item.left);
        end
        if (!head_item.last_col)
        begin
            sum = sum + SUM_BITS'(head_item.right);
        end
    end

    assign prod = (2*SUM_BITS)'(a_sum_reg) * (2*SUM_BITS)'(DIV3_MUL);
    assign quot = a_div3_reg ? VALUE_BITS'(prod >> DIV3_SHIFT)
                             : VALUE_BITS'(a_sum_reg >> 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_load)
            begin
                a_valid_reg <= pop;
            end
            if (out_adv)
            begin
                out_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_sum_reg   <= sum;
            a_div3_reg  <= head_item.first_col || head_item.last_col;
            a_last_reg  <= head_item.last_col;
            a_lastf_reg <= head_item.last_frame;
        end
        if (out_adv)
        begin
            out_data_reg  <= quot;
            out_last_reg  <= a_last_reg;
            out_lastf_reg <= a_lastf_reg;
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign new_value     = out_data_reg;
    assign last_in_row   = out_last_reg;
    assign last_in_frame = out_lastf_reg;

    a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && last_in_frame) |-> last_in_row)
        else $error("frame end flagged off the row end");

endmodule

// ===== sv/heat_diffusion_stencil.sv =====
// A beat passes the stage-1 registers, job queue, sum and output registers.
// Throughput: one beat per cycle in both directions while m_tready is high;
// each line memory does its reads and one write every cycle. With m_tready
// low, s_tready drops when queued jobs plus the front-stage beat reach four.
// Rows 0 and 1 of a frame and beats after the closing halo give no result.
// Reset (rst_n low, async): row_width=1024, row_count=256, counters cleared;
// line memories are not cleared and are defined by the first halo rows.
module heat_diffusion_stencil #(
    parameter int MAX_WIDTH = hds_pkg::HDS_MAX_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,   // [15:0] cell_value
    input  logic [0:0]                         s_tuser,   // [0] start_of_frame
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,   // [15:0] new_value
    output logic                               m_tlast,   // last_in_row
    output logic [0:0]                         m_tuser,   // [0] last_in_frame
    // config writes: index 0 row_width, index 1 row_count
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hds_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [hds_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import hds_pkg::*;

    hds_item_t  push_item;
    hds_item_t  head_item;
    hds_qstat_t qstat;
    logic       push;
    logic       pop;

    // config registers take a write every cycle
    assign cfg_ready = 1'b1;

    // Front: classifies each beat (row/column, halo, edge columns), reads
    // the upper and middle line memories and queues a job for slice rows.
    hds_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .cell_value     (s_tdata[VALUE_BITS-1:0]),
        .start_of_frame (s_tuser[0]),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .qstat          (qstat),
        .push           (push),
        .push_item      (push_item)
    );

    // Jobs wait here so the front keeps taking beats while m_tready is low.
    hds_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .stat      (qstat)
    );

    // Back: sum of neighbors, divide by 3 on edge columns or 4 inside,
    // then the output register.
    hds_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_item     (head_item),
        .qstat         (qstat),
        .pop           (pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .new_value     (m_tdata[VALUE_BITS-1:0]),
        .last_in_row   (m_tlast),
        .last_in_frame (m_tuser[0])
    );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for heat_diffusion_stencil: random and directed frames,
// with results predicted in-bench and compared beat by beat.
// Depends on hds_pkg and the heat_diffusion_stencil RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hds_pkg::*;

    localparam int RANDOM_CELLS = 1800;
    localparam int SETTLE_CYCLES = 8;      // keep some margin after the last result
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int REPORT_LIMIT = 10;
    localparam int HOLD_WIDTH = 48;
    localparam int HOLD_ROWS = 4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = '1;

    typedef enum int {FRAME_CLEAN, FRAME_ABORTED, FRAME_TRAILING, FRAME_RESIZED} frame_kind_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  sof;
    } cell_beat_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  row_end;
        logic                  frame_end;
    } heat_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [15:0]               s_tdata = '0;    // [15:0] cell_value
    logic [0:0]                s_tuser = '0;    // [0] start_of_frame
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [15:0]               m_tdata;         // [15:0] new_value
    logic                      m_tlast;         // last_in_row
    logic [0:0]                m_tuser;         // [0] last_in_frame
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    heat_diffusion_stencil dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Stimulus side state
    cell_beat_t   cell_backlog[$];
    heat_result_t heat_expected[$];
    int unsigned  send_idle_pct = 35;
    int unsigned  take_idle_pct = 71;
    int unsigned  hold_req = 0;
    int unsigned  hold_ack = 0;
    int unsigned  hold_left = 0;
    int unsigned  mismatches = 0;

    // Predictor state: registers, line buffers and stream position
    logic [ROW_WIDTH_BITS-1:0] width_reg = ROW_WIDTH_RESET;
    logic [ROW_COUNT_BITS-1:0] rows_reg = ROW_COUNT_RESET;
    logic [VALUE_BITS-1:0]     upper_mem [HDS_MAX_WIDTH];
    logic [VALUE_BITS-1:0]     middle_mem [HDS_MAX_WIDTH];
    logic [VALUE_BITS-1:0]     left_val = '0;
    int unsigned               col_pos = 0;
    int unsigned               row_pos = 0;

    // Advance the predicted sweep by one accepted cell; queue a result for
    // slice rows (stream row 2 up to the closing halo).
    function automatic void diffuse_cell(logic [VALUE_BITS-1:0] heat, logic sof);
        int unsigned w;
        int unsigned last_row;
        int unsigned c;
        logic [SUM_BITS-1:0] sum;
        logic first_col;
        logic last_col;
        logic [VALUE_BITS-1:0] mid_val;
        heat_result_t res;
        w = (width_reg < 2) ? 2 : ((width_reg > HDS_MAX_WIDTH) ? HDS_MAX_WIDTH : width_reg);
        last_row = ((rows_reg < 2) ? 2 : rows_reg) + 1;
        if (sof)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        if (row_pos > last_row)
            return;
        // a column past a narrowed width counts as the last column
        c = (col_pos > w - 1) ? w - 1 : col_pos;
        first_col = (c == 0);
        last_col = (c == w - 1);
        mid_val = middle_mem[c];
        if (row_pos >= 2)
        begin
            sum = SUM_BITS'(upper_mem[c]) + SUM_BITS'(heat);
            if (!first_col)
                sum = sum + SUM_BITS'(left_val);
            if (!last_col)
                sum = sum + SUM_BITS'(middle_mem[c + 1]);
            res.value = (first_col || last_col) ? VALUE_BITS'(sum / 3) : sum[SUM_BITS-1:2];
            res.row_end = last_col;
            res.frame_end = last_col && (row_pos == last_row);
            heat_expected.push_back(res);
        end
        left_val = mid_val;
        upper_mem[c] = mid_val;
        middle_mem[c] = heat;
        if (last_col)
        begin
            col_pos = 0;
            row_pos = row_pos + 1;
        end
        else
            col_pos = c + 1;
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // Sender: presents queued cells, idling at random
    always @(posedge clk or negedge rst_n)
    begin : cell_driver
        cell_beat_t next_beat;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (cell_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_beat = cell_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= next_beat.value;
                s_tuser <= next_beat.sof;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random backpressure, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_ack != hold_req)
        begin
            hold_ack <= hold_req;
            hold_left <= LONG_HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= take_idle_pct);
    end

    // Monitor: input beats feed the predictor with the registers in force
    // before this edge, then config writes land; result beats are checked
    always @(posedge clk)
    begin : monitor
        heat_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                diffuse_cell(s_tdata, s_tuser[0]);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ROW_WIDTH: width_reg = cfg_data[ROW_WIDTH_BITS-1:0];
                    CFG_ROW_COUNT: rows_reg = cfg_data[ROW_COUNT_BITS-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (heat_expected.size() == 0)
                    note_mismatch($sformatf("unexpected result beat data=%h last=%b user=%b",
                                            m_tdata, m_tlast, m_tuser));
                else
                begin
                    want = heat_expected.pop_front();
                    if (m_tdata !== want.value || m_tlast !== want.row_end
                        || m_tuser[0] !== want.frame_end)
                        note_mismatch($sformatf(
                            "mismatch (exp/got): value %h/%h row_end %b/%b frame_end %b/%b",
                            want.value, m_tdata, want.row_end, m_tlast,
                            want.frame_end, m_tuser[0]));
                end
            end
        end
    end

    function automatic logic [VALUE_BITS-1:0] random_heat();
        if ($urandom_range(15) == 0)
            return $urandom_range(1) ? '1 : '0;
        return VALUE_BITS'($urandom);
    endfunction

    task automatic push_cells(int n, bit sof_first);
        for (int i = 0; i < n; i++)
            cell_backlog.push_back('{value: random_heat(), sof: sof_first && (i == 0)});
    endtask

    task automatic push_fixed(logic [VALUE_BITS-1:0] value, int n, bit sof_first);
        for (int i = 0; i < n; i++)
            cell_backlog.push_back('{value: value, sof: sof_first && (i == 0)});
    endtask

    // Wait until every queued cell is taken and every result is back, then
    // let the pipeline settle (row 0/1 cells leave no result to wait for).
    task automatic wait_drained();
        do
            @(negedge clk);
        while (cell_backlog.size() != 0 || s_tvalid || heat_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, int unsigned value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= CFG_DATA_BITS'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int unsigned random_cells;
        int unsigned mode;
        int unsigned width_val;
        int unsigned rows_val;
        int unsigned w_eff;
        int unsigned rows_eff;
        int unsigned frame_len;
        int unsigned roll;
        bit big_done;
        frame_kind_t kind;

        random_cells = 0;
        big_done = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: smallest width, row count below range, unused index;
        // first frame carries no start mark.
        write_reg(CFG_ROW_WIDTH, 2);
        write_reg(CFG_ROW_COUNT, 0);
        write_reg(CFG_UNUSED, 16'hA5A5);
        push_fixed(16'hFFFF, 2, 0);
        push_fixed(16'h0000, 1, 0);
        push_fixed(16'hFFFF, 3, 0);
        push_fixed(16'h0000, 2, 0);
        wait_drained();

        // Full-scale four-neighbor sums, an aborted frame, then trailing cells
        write_reg(CFG_ROW_WIDTH, 3);
        write_reg(CFG_ROW_COUNT, 2);
        push_cells(4, 1);
        push_fixed(16'hFFFF, 12, 1);
        push_fixed(16'h0000, 2, 0);
        wait_drained();

        // Largest row count, then shrink it mid-frame so the row is past the end
        write_reg(CFG_ROW_COUNT, 65535);
        push_cells(12, 1);
        wait_drained();
        write_reg(CFG_ROW_COUNT, 2);
        push_cells(2, 0);
        wait_drained();

        // Random phases: config, then one to three frames
        while (random_cells < RANDOM_CELLS)
        begin
            mode = random_cells * 3 / RANDOM_CELLS;
            send_idle_pct = (mode == 0) ? 35 : ((mode == 1) ? 71 : 0);
            take_idle_pct = (mode == 0) ? 71 : ((mode == 1) ? 35 : 0);
            wait_drained();

            if (mode == 2 && !big_done)
            begin
                // long receiver hold-off while a full frame streams in
                big_done = 1;
                write_reg(CFG_ROW_WIDTH, HOLD_WIDTH);
                write_reg(CFG_ROW_COUNT, HOLD_ROWS);
                hold_req = hold_req + 1;
                frame_len = HOLD_WIDTH * (HOLD_ROWS + 2);
                push_cells(frame_len, 1);
                random_cells += frame_len;
                continue;
            end

            roll = $urandom_range(99);
            width_val = (roll < 70) ? $urandom_range(2, 12) :
                        (roll < 92) ? $urandom_range(13, 48) : $urandom_range(0, 1);
            roll = $urandom_range(99);
            rows_val = (roll < 75) ? $urandom_range(2, 6) :
                       (roll < 88) ? $urandom_range(7, 12) : $urandom_range(0, 1);
            write_reg(CFG_ROW_WIDTH, width_val);
            write_reg(CFG_ROW_COUNT, rows_val);
            w_eff = (width_val < 2) ? 2 : width_val;
            rows_eff = (rows_val < 2) ? 2 : rows_val;

            repeat ($urandom_range(1, 3))
            begin
                frame_len = w_eff * (rows_eff + 2);
                roll = $urandom_range(99);
                kind = (roll < 70) ? FRAME_CLEAN : (roll < 80) ? FRAME_ABORTED :
                       (roll < 90) ? FRAME_TRAILING : FRAME_RESIZED;
                case (kind)
                    FRAME_ABORTED:
                    begin
                        push_cells($urandom_range(1, frame_len - 1), 1);
                        push_cells(frame_len, 1);
                    end
                    FRAME_TRAILING:
                    begin
                        push_cells(frame_len, 1);
                        push_cells($urandom_range(1, 4), 0);
                    end
                    FRAME_RESIZED:
                    begin
                        // only narrow the width, so no unwritten line entry is read
                        push_cells($urandom_range(1, frame_len - 1), 1);
                        wait_drained();
                        if ($urandom_range(1))
                        begin
                            w_eff = $urandom_range(2, w_eff);
                            write_reg(CFG_ROW_WIDTH, w_eff);
                        end
                        else
                        begin
                            rows_val = $urandom_range(0, 8);
                            write_reg(CFG_ROW_COUNT, rows_val);
                            rows_eff = (rows_val < 2) ? 2 : rows_val;
                        end
                        // enough cells to finish the frame; extras are ignored
                        push_cells(w_eff * (rows_eff + 2), 0);
                    end
                    default:
                        push_cells(frame_len, 1);
                endcase
                random_cells += frame_len;
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && heat_expected.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
